@@ rtl/irpd_pkg.sv @@
// Shared types and constants for the infrared pulse-distance frame decoder.
// Used by irpd_cfg_regs and ir_pulse_distance_frame_decoder_unit; no dependencies.
`timescale 1ns / 1ps

package irpd_pkg;

    localparam int DUR_W     = 16;
    localparam int CODE_W    = 25;
    localparam int TALLY_W   = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int M_TDATA_W = 40;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HEADER_MARK_MIN = 3'd0,
        REG_HEADER_MARK_MAX = 3'd1,
        REG_PULSE_MARK_MIN  = 3'd2,
        REG_PULSE_MARK_MAX  = 3'd3,
        REG_SPACE_ONE_MIN   = 3'd4,
        REG_SPACE_ONE_MAX   = 3'd5,
        REG_SPACE_ZERO_MIN  = 3'd6,
        REG_SPACE_ZERO_MAX  = 3'd7
    } irpd_reg_idx_t;

    localparam logic [DUR_W-1:0] RST_HEADER_MARK_MIN = 16'd31;
    localparam logic [DUR_W-1:0] RST_HEADER_MARK_MAX = 16'd53;
    localparam logic [DUR_W-1:0] RST_PULSE_MARK_MIN  = 16'd8;
    localparam logic [DUR_W-1:0] RST_PULSE_MARK_MAX  = 16'd15;
    localparam logic [DUR_W-1:0] RST_SPACE_ONE_MIN   = 16'd13;
    localparam logic [DUR_W-1:0] RST_SPACE_ONE_MAX   = 16'd23;
    localparam logic [DUR_W-1:0] RST_SPACE_ZERO_MIN  = 16'd6;
    localparam logic [DUR_W-1:0] RST_SPACE_ZERO_MAX  = 16'd11;

    typedef struct packed {
        logic [DUR_W-1:0] lo;
        logic [DUR_W-1:0] hi;
    } irpd_window_t;

    typedef struct packed {
        irpd_window_t header_mark;
        irpd_window_t pulse_mark;
        irpd_window_t space_one;
        irpd_window_t space_zero;
    } irpd_windows_t;

    function automatic logic in_window(input logic [DUR_W-1:0] d, input irpd_window_t w);
        return (d >= w.lo) && (d <= w.hi);
    endfunction

endpackage

@@ rtl/irpd_cfg_regs.sv @@
// Tick-window configuration registers for the pulse-distance decoder.
// Depends on irpd_pkg.
`timescale 1ns / 1ps

module irpd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [irpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [irpd_pkg::DUR_W-1:0]        cfg_wdata,
    output irpd_pkg::irpd_windows_t           windows
);
    import irpd_pkg::*;

    irpd_windows_t win_reg;
    irpd_windows_t win_next;

    always_comb begin
        win_next = win_reg;
        if (cfg_we) begin
            case (irpd_reg_idx_t'(cfg_addr))
                REG_HEADER_MARK_MIN: win_next.header_mark.lo = cfg_wdata;
                REG_HEADER_MARK_MAX: win_next.header_mark.hi = cfg_wdata;
                REG_PULSE_MARK_MIN:  win_next.pulse_mark.lo  = cfg_wdata;
                REG_PULSE_MARK_MAX:  win_next.pulse_mark.hi  = cfg_wdata;
                REG_SPACE_ONE_MIN:   win_next.space_one.lo   = cfg_wdata;
                REG_SPACE_ONE_MAX:   win_next.space_one.hi   = cfg_wdata;
                REG_SPACE_ZERO_MIN:  win_next.space_zero.lo  = cfg_wdata;
                REG_SPACE_ZERO_MAX:  win_next.space_zero.hi  = cfg_wdata;
                default:             win_next = win_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.header_mark.lo <= RST_HEADER_MARK_MIN;
            win_reg.header_mark.hi <= RST_HEADER_MARK_MAX;
            win_reg.pulse_mark.lo  <= RST_PULSE_MARK_MIN;
            win_reg.pulse_mark.hi  <= RST_PULSE_MARK_MAX;
            win_reg.space_one.lo   <= RST_SPACE_ONE_MIN;
            win_reg.space_one.hi   <= RST_SPACE_ONE_MAX;
            win_reg.space_zero.lo  <= RST_SPACE_ZERO_MIN;
            win_reg.space_zero.hi  <= RST_SPACE_ZERO_MAX;
        end else begin
            win_reg <= win_next;
        end
    end

    assign windows = win_reg;

endmodule

@@ rtl/ir_pulse_distance_frame_decoder_unit.sv @@
// Infrared pulse-distance frame decoder: top level with input stage, frame
// sequencing and result register. Depends on irpd_pkg and irpd_cfg_regs.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   input   | in  | s_tvalid/s_tready  | s_tdata: duration_ticks; s_tuser: frame_first
//   result  | out | m_tvalid/m_tready  | m_tdata: code, bad marks, bad spaces;
//           |     |                    | m_tuser: status
//   config  | in  | cfg_we             | cfg_addr, cfg_wdata
//
// One input transaction per cycle while the result is not stalled; an item
// that ends a frame passes the input register, then the result register,
// which raises m_tvalid. Frame state updates once per item in a single pass
// between the two registers. Reset clears position, shift register, tallies
// and both stage valids, and loads the default tick windows. A stalled result
// holds the result register and, through it, the input stage; with the result
// register free the input keeps flowing.
`timescale 1ns / 1ps

module ir_pulse_distance_frame_decoder_unit #(
    parameter int FRAME_BITS = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    // slave input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] duration_ticks
    input  logic        s_tuser,   // [0] frame_first
    // master result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [24:0] code_value, [29:25] bad_mark_count,
                                   // [34:30] bad_space_count, [39:35] zero
    output logic        m_tuser,   // [0] status
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import irpd_pkg::*;

    localparam int POS_W = $clog2(2 * FRAME_BITS + 2);
    localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HEADER = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BITS   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(2 * FRAME_BITS + 1);

    irpd_windows_t windows;

    irpd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .windows   (windows)
    );

    // input stage
    logic             in_valid_reg, in_valid_next;
    logic [DUR_W-1:0] in_dur_reg;
    logic             in_first_reg;

    // frame state
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [TALLY_W-1:0]    mark_tally_reg, mark_tally_next;
    logic [TALLY_W-1:0]    space_tally_reg, space_tally_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic [TALLY_W-1:0] out_mark_reg, out_mark_next;
    logic [TALLY_W-1:0] out_space_reg, out_space_next;

    logic            proc_ready;
    logic            proc_fire;
    logic            s_fire;
    logic            result_load;
    logic [FRAME_BITS:0] shift_ext;

    assign proc_ready = !out_valid_reg || m_tready;
    assign proc_fire  = in_valid_reg && proc_ready;
    assign s_tready   = !in_valid_reg || proc_ready;
    assign s_fire     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_ready) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        pos_next         = pos_reg;
        shift_next       = shift_reg;
        mark_tally_next  = mark_tally_reg;
        space_tally_next = space_tally_reg;
        result_load      = 1'b0;
        out_status_next  = out_status_reg;
        out_code_next    = out_code_reg;
        out_mark_next    = out_mark_reg;
        out_space_next   = out_space_reg;
        shift_ext        = {shift_reg, 1'b0};

        if (proc_fire) begin
            if (in_first_reg) begin
                // gap entry: abandon any frame and wait for the header
                shift_next       = '0;
                mark_tally_next  = '0;
                space_tally_next = '0;
                pos_next         = POS_HEADER;
            end else if (pos_reg == POS_IDLE) begin
                pos_next = POS_IDLE;
            end else if (pos_reg == POS_HEADER) begin
                if (!in_window(in_dur_reg, windows.header_mark)) begin
                    result_load      = 1'b1;
                    out_status_next  = 1'b1;
                    out_code_next    = '0;
                    out_mark_next    = '0;
                    out_space_next   = '0;
                    shift_next       = '0;
                    mark_tally_next  = '0;
                    space_tally_next = '0;
                    pos_next         = POS_IDLE;
                end else begin
                    pos_next = POS_BITS;
                end
            end else if (!pos_reg[0]) begin
                // bit mark: count only
                if (!in_window(in_dur_reg, windows.pulse_mark) &&
                    mark_tally_reg != TALLY_MAX) begin
                    mark_tally_next = mark_tally_reg + 1'b1;
                end
                pos_next = pos_reg + 1'b1;
            end else begin
                // bit space: one-window first, then zero-window
                if (in_window(in_dur_reg, windows.space_one)) begin
                    shift_ext  = {shift_reg, 1'b1};
                    shift_next = shift_ext[FRAME_BITS-1:0];
                end else if (in_window(in_dur_reg, windows.space_zero)) begin
                    shift_ext  = {shift_reg, 1'b0};
                    shift_next = shift_ext[FRAME_BITS-1:0];
                end else if (space_tally_reg != TALLY_MAX) begin
                    space_tally_next = space_tally_reg + 1'b1;
                end

                if (pos_reg == POS_LAST) begin
                    result_load      = 1'b1;
                    out_status_next  = 1'b0;
                    out_code_next    = CODE_W'({{CODE_W{1'b0}}, shift_next});
                    out_mark_next    = mark_tally_next;
                    out_space_next   = space_tally_next;
                    shift_next       = '0;
                    mark_tally_next  = '0;
                    space_tally_next = '0;
                    pos_next         = POS_IDLE;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (result_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pos_reg         <= POS_IDLE;
            shift_reg       <= '0;
            mark_tally_reg  <= '0;
            space_tally_reg <= '0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            pos_reg         <= pos_next;
            shift_reg       <= shift_next;
            mark_tally_reg  <= mark_tally_next;
            space_tally_reg <= space_tally_next;
        end
    end

    // payload registers: load on transaction, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_dur_reg   <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (result_load) begin
            out_status_reg <= out_status_next;
            out_code_reg   <= out_code_next;
            out_mark_reg   <= out_mark_next;
            out_space_reg  <= out_space_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(M_TDATA_W - CODE_W - 2 * TALLY_W){1'b0}},
                       out_space_reg, out_mark_reg, out_code_reg};

endmodule
